[rtl/erdop_pkg.sv]
// Shared types and codes for the event ring with drop-oldest and purge.
package erdop_pkg;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_PURGE = 2'd2
	} erdop_op_t;

	// One queued event record
	typedef struct packed {
		logic [15:0] window;
		logic [15:0] etype;
		logic [31:0] stamp;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] size_w;
		logic [15:0] size_h;
		logic [31:0] key;
	} erdop_entry_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic purge_start;
		logic purge_run;
		logic purge_finish;
	} erdop_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       scan_done;
		logic       res_free;
	} erdop_stat_t;

	// Result payload apart from the fill count
	typedef struct packed {
		logic         event_valid;
		logic         dropped_oldest;
		erdop_entry_t ev;
	} erdop_result_t;

endpackage

[rtl/erdop_ctrl.sv]
// Sequencing state machine for the event ring.
module erdop_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  erdop_pkg::erdop_stat_t stat,
	output logic                  req_stall,
	output erdop_pkg::erdop_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PURGE
	} state_t;

	state_t state_q;
	logic   stall_q;
	logic   is_purge;

	assign is_purge  = (stat.op == erdop_pkg::OP_PURGE);
	assign req_stall = stall_q;

	always_comb begin
		cmd              = '0;
		cmd.capture      = (state_q == ST_IDLE) && req_valid;
		cmd.exec         = (state_q == ST_EXEC) && !is_purge && stat.res_free;
		cmd.purge_start  = (state_q == ST_EXEC) && is_purge;
		cmd.purge_run    = (state_q == ST_PURGE);
		cmd.purge_finish = (state_q == ST_PURGE) && stat.scan_done && stat.res_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
						stall_q <= 1'b1;
					end
				end
				ST_EXEC: begin
					if (is_purge) begin
						state_q <= ST_PURGE;
					end else if (stat.res_free) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				ST_PURGE: begin
					if (stat.scan_done && stat.res_free) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

[rtl/erdop_dpath.sv]
// Entry memory, ring pointers, purge scan and result register.
module erdop_dpath #(
	parameter  int QUEUE_DEPTH = 32,
	localparam int CW          = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  erdop_pkg::erdop_cmd_t  cmd,
	output erdop_pkg::erdop_stat_t stat,
	input  logic [1:0]            op,
	input  logic [15:0]           window_id,
	input  logic [15:0]           event_type,
	input  logic [31:0]           timestamp,
	input  logic [15:0]           pos_x,
	input  logic [15:0]           pos_y,
	input  logic [15:0]           size_w,
	input  logic [15:0]           size_h,
	input  logic [31:0]           key_code,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic                  event_valid,
	output logic                  dropped_oldest,
	output logic [CW-1:0]         fill_count,
	output logic [15:0]           out_window,
	output logic [15:0]           out_type,
	output logic [31:0]           out_time,
	output logic [15:0]           out_x,
	output logic [15:0]           out_y,
	output logic [15:0]           out_w,
	output logic [15:0]           out_h,
	output logic [31:0]           out_key
);

	localparam int             PW      = $clog2(QUEUE_DEPTH);
	localparam int             SW      = CW + 1;
	localparam logic [CW-1:0]  DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [SW-1:0]  DEPTH_S = SW'(QUEUE_DEPTH);
	localparam logic [PW-1:0]  LAST_P  = PW'(QUEUE_DEPTH - 1);

	function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
		input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(off);
		if (s >= DEPTH_S)
			s = s - DEPTH_S;
		return s[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
		return (p == LAST_P) ? '0 : p + PW'(1);
	endfunction

	// captured item
	logic [1:0]              op_q;
	logic [15:0]             win_q;
	erdop_pkg::erdop_entry_t entry_in_q;

	// ring state
	logic [PW-1:0] rp_q, wp_q;
	logic [CW-1:0] count_q;

	// purge scan
	logic [CW-1:0] scan_q, kept_q;
	logic          v_s1;

	// storage
	erdop_pkg::erdop_entry_t mem [QUEUE_DEPTH];
	erdop_pkg::erdop_entry_t rdata_q;

	// result register
	logic                     rsp_valid_q;
	erdop_pkg::erdop_result_t res_q;
	logic [CW-1:0]            fill_q;

	logic                     full, issue, keep_hit, we, load, res_free;
	logic [PW-1:0]            raddr, waddr, kept_slot, wp_expect;
	erdop_pkg::erdop_entry_t  wdata;
	logic [PW-1:0]            rp_d, wp_d;
	logic [CW-1:0]            count_d, fill_d;
	erdop_pkg::erdop_result_t res_d;

	assign full      = (count_q == DEPTH_C);
	assign issue     = cmd.purge_run && (scan_q < count_q);
	assign keep_hit  = v_s1 && (rdata_q.window != win_q);
	assign kept_slot = ring_add(rp_q, kept_q);
	assign raddr     = cmd.purge_run ? ring_add(rp_q, scan_q) : rp_q;
	assign we        = (cmd.exec && (op_q == erdop_pkg::OP_PUSH)) || keep_hit;
	assign waddr     = keep_hit ? kept_slot : wp_q;
	assign wdata     = keep_hit ? rdata_q : entry_in_q;
	assign load      = cmd.exec || cmd.purge_finish;
	assign res_free  = !rsp_valid_q || !rsp_stall;
	assign wp_expect = ring_add(rp_q, count_q);

	always_comb begin
		stat           = '0;
		stat.op        = op_q;
		stat.scan_done = (scan_q == count_q) && !v_s1;
		stat.res_free  = res_free;
	end

	// next ring state and result
	always_comb begin
		rp_d    = rp_q;
		wp_d    = wp_q;
		count_d = count_q;
		res_d   = '0;
		if (cmd.purge_finish) begin
			count_d = kept_q;
			wp_d    = kept_slot;
		end else if (cmd.exec) begin
			case (op_q)
				erdop_pkg::OP_PUSH: begin
					wp_d = next_slot(wp_q);
					if (full) begin
						rp_d                 = next_slot(rp_q);
						res_d.dropped_oldest = 1'b1;
					end else begin
						count_d = count_q + CW'(1);
					end
				end
				erdop_pkg::OP_POP: begin
					if (count_q != '0) begin
						rp_d              = next_slot(rp_q);
						count_d           = count_q - CW'(1);
						res_d.event_valid = 1'b1;
						res_d.ev          = rdata_q;
					end
				end
				default: begin
				end
			endcase
		end
		fill_d = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q        <= '0;
			wp_q        <= '0;
			count_q     <= '0;
			scan_q      <= '0;
			kept_q      <= '0;
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rp_q    <= rp_d;
			wp_q    <= wp_d;
			count_q <= count_d;
			if (cmd.purge_start) begin
				scan_q <= '0;
				kept_q <= '0;
				v_s1   <= 1'b0;
			end else begin
				v_s1 <= issue;
				if (issue)
					scan_q <= scan_q + CW'(1);
				if (keep_hit)
					kept_q <= kept_q + CW'(1);
			end
			if (load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q                <= op;
			win_q               <= window_id;
			entry_in_q.window   <= window_id;
			entry_in_q.etype    <= event_type;
			entry_in_q.stamp    <= timestamp;
			entry_in_q.pos_x    <= pos_x;
			entry_in_q.pos_y    <= pos_y;
			entry_in_q.size_w   <= size_w;
			entry_in_q.size_h   <= size_h;
			entry_in_q.key      <= key_code;
		end
		if (load) begin
			res_q  <= res_d;
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rsp_valid      = rsp_valid_q;
	assign event_valid    = res_q.event_valid;
	assign dropped_oldest = res_q.dropped_oldest;
	assign fill_count     = fill_q;
	assign out_window     = res_q.ev.window;
	assign out_type       = res_q.ev.etype;
	assign out_time       = res_q.ev.stamp;
	assign out_x          = res_q.ev.pos_x;
	assign out_y          = res_q.ev.pos_y;
	assign out_w          = res_q.ev.size_w;
	assign out_h          = res_q.ev.size_h;
	assign out_key        = res_q.ev.key;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count above depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q == wp_expect)
		else $error("write pointer not count slots past read pointer");

	a_kept_le_scan: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= scan_q)
		else $error("purge kept more entries than it scanned");

	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> res_free)
		else $error("result register overwritten before it was taken");

endmodule

[rtl/event_ring_drop_oldest_purge.sv]
// Top level of the event ring with drop-oldest overflow and window purge.
//
// A circular queue of QUEUE_DEPTH event records. Each request item carries
// an op: push stores an event (when the queue is full the oldest event is
// dropped and dropped_oldest is set), pop returns the oldest event with
// event_valid set (or event_valid low and zero fields on an empty queue),
// purge removes every queued event of the given window and packs the rest
// in order. Op code 3 changes nothing. Every request gives exactly one
// response item carrying the fill count after the operation.
// Push, pop and the unused code are accepted, then executed into the
// response register; req_stall is high from acceptance until the execute,
// so the next item is accepted only after the last one has executed. A
// purge scans the queue through the single registered read port of the
// entry memory, one entry a cycle with the compacting write in the cycle
// after each read, and after acceptance it holds req_stall high until the
// scan is done. A waiting response does not block acceptance of the next
// item; it only holds off the execute cycle. The entry memory has no reset
// or clearing pass: only slots holding queued events are read.
module event_ring_drop_oldest_purge #(
	parameter  int QUEUE_DEPTH = 32,
	localparam int CW          = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  logic [1:0]    op,
	input  logic [15:0]   window_id,
	input  logic [15:0]   event_type,
	input  logic [31:0]   timestamp,
	input  logic [15:0]   pos_x,
	input  logic [15:0]   pos_y,
	input  logic [15:0]   size_w,
	input  logic [15:0]   size_h,
	input  logic [31:0]   key_code,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output logic          event_valid,
	output logic          dropped_oldest,
	output logic [CW-1:0] fill_count,
	output logic [15:0]   out_window,
	output logic [15:0]   out_type,
	output logic [31:0]   out_time,
	output logic [15:0]   out_x,
	output logic [15:0]   out_y,
	output logic [15:0]   out_w,
	output logic [15:0]   out_h,
	output logic [31:0]   out_key
);

	erdop_pkg::erdop_cmd_t  cmd;
	erdop_pkg::erdop_stat_t stat;

	// sequencing: idle / execute / purge scan
	erdop_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.stat      (stat),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	// memory, pointers, count and response register
	erdop_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.op             (op),
		.window_id      (window_id),
		.event_type     (event_type),
		.timestamp      (timestamp),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.size_w         (size_w),
		.size_h         (size_h),
		.key_code       (key_code),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.event_valid    (event_valid),
		.dropped_oldest (dropped_oldest),
		.fill_count     (fill_count),
		.out_window     (out_window),
		.out_type       (out_type),
		.out_time       (out_time),
		.out_x          (out_x),
		.out_y          (out_y),
		.out_w          (out_w),
		.out_h          (out_h),
		.out_key        (out_key)
	);

endmodule

[test/tb_top.sv]
// Self-checking testbench for event_ring_drop_oldest_purge.
module tb_top;

	localparam int QUEUE_DEPTH = 32;
	localparam int ITEM_GOAL   = 650;  // rough size of the random part
	localparam int TAIL_ITEMS  = 60;   // last stretch runs with no idling
	localparam int IDLE_LIMIT  = 2000; // cycles with no handshake before giving up
	localparam int SETTLE      = 20;   // cycles watched after the last result
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// One request as queued for the driver; drain marks a pause in the traffic
	typedef struct packed {
		logic                    drain;
		logic [1:0]              code;
		erdop_pkg::erdop_entry_t ev;
	} req_item_t;

	typedef struct packed {
		logic                    ev_valid;
		logic                    dropped;
		logic [5:0]              fill;
		erdop_pkg::erdop_entry_t ev;
	} ring_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  op = 2'd0;
	logic [15:0] window_id = '0;
	logic [15:0] event_type = '0;
	logic [31:0] timestamp = '0;
	logic [15:0] pos_x = '0;
	logic [15:0] pos_y = '0;
	logic [15:0] size_w = '0;
	logic [15:0] size_h = '0;
	logic [31:0] key_code = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic        event_valid;
	logic        dropped_oldest;
	logic [5:0]  fill_count;
	logic [15:0] out_window;
	logic [15:0] out_type;
	logic [31:0] out_time;
	logic [15:0] out_x;
	logic [15:0] out_y;
	logic [15:0] out_w;
	logic [15:0] out_h;
	logic [31:0] out_key;

	event_ring_drop_oldest_purge #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.op(op), .window_id(window_id), .event_type(event_type), .timestamp(timestamp),
		.pos_x(pos_x), .pos_y(pos_y), .size_w(size_w), .size_h(size_h),
		.key_code(key_code),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.event_valid(event_valid), .dropped_oldest(dropped_oldest),
		.fill_count(fill_count), .out_window(out_window), .out_type(out_type),
		.out_time(out_time), .out_x(out_x), .out_y(out_y), .out_w(out_w),
		.out_h(out_h), .out_key(out_key)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor: a behavioural copy of the ring. Pointers are five bits
	// wide, so wrap-around at the depth comes for free.
	// ---------------------------------------------------------------
	erdop_pkg::erdop_entry_t ring_mem [QUEUE_DEPTH];
	logic [4:0]   ring_rd = '0;
	logic [4:0]   ring_wr = '0;
	logic [5:0]   ring_cnt = '0;

	function automatic ring_result_t ring_apply(req_item_t it);
		ring_result_t r;
		logic [5:0]   kept;
		logic [4:0]   src;
		logic [4:0]   dst;
		int           i;
		r = '0;
		case (it.code)
			erdop_pkg::OP_PUSH: begin
				ring_mem[ring_wr] = it.ev;
				ring_wr = ring_wr + 5'd1;
				// full ring: the new event takes the oldest one's place
				if (ring_cnt == QUEUE_DEPTH) begin
					ring_rd = ring_rd + 5'd1;
					r.dropped = 1'b1;
				end else begin
					ring_cnt = ring_cnt + 6'd1;
				end
			end
			erdop_pkg::OP_POP: begin
				// empty ring answers with all event fields at zero
				if (ring_cnt != 0) begin
					r.ev_valid = 1'b1;
					r.ev = ring_mem[ring_rd];
					ring_rd = ring_rd + 5'd1;
					ring_cnt = ring_cnt - 6'd1;
				end
			end
			erdop_pkg::OP_PURGE: begin
				// survivors slide down towards the read pointer, order kept
				kept = '0;
				for (i = 0; i < ring_cnt; i++) begin
					src = ring_rd + i[4:0];
					if (ring_mem[src].window != it.ev.window) begin
						dst = ring_rd + kept[4:0];
						ring_mem[dst] = ring_mem[src];
						kept = kept + 6'd1;
					end
				end
				ring_cnt = kept;
				ring_wr = ring_rd + kept[4:0];
			end
			default: ; // unused code: only the fill count comes back
		endcase
		r.fill = ring_cnt;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	req_item_t    req_backlog [$];  // items still to be offered
	ring_result_t rsp_due [$];      // predicted results, oldest first
	int           item_total = 0;
	int           accepted_items = 0;
	int           mismatches = 0;

	// Windows mostly come from a handful of ids so that purges find matches
	function automatic logic [15:0] pick_window();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 16'($urandom_range(0, 3));
		else if (r < 80)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic req_item_t event_item(logic [1:0] code, logic [15:0] win);
		req_item_t it;
		it.drain     = 1'b0;
		it.code      = code;
		it.ev.window = win;
		it.ev.etype  = 16'($urandom);
		it.ev.stamp  = $urandom;
		it.ev.pos_x  = 16'($urandom);
		it.ev.pos_y  = 16'($urandom);
		it.ev.size_w = 16'($urandom);
		it.ev.size_h = 16'($urandom);
		it.ev.key    = $urandom;
		return it;
	endfunction

	task automatic queue_item(req_item_t it);
		req_backlog.push_back(it);
		item_total++;
	endtask

	// Pause marker: the driver holds off until every result is in
	task automatic queue_pause();
		req_item_t it;
		it = '0;
		it.drain = 1'b1;
		req_backlog.push_back(it);
	endtask

	// ---------------------------------------------------------------
	// Driver: presents items at the falling edge, holds them while
	// stalled, and inserts idle bursts at the current gap rate.
	// ---------------------------------------------------------------
	req_item_t req_cur = '0;   // item now on the request ports
	logic      req_taken = 1'b0; // request handshake seen at the last rising edge
	int        gap_pct = 0;    // idle rate for both sides, redrawn every 64 items
	int        gap_left = 0;
	int        hold_left = 0;
	int        issued = 0;
	req_item_t nxt;

	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_valid && !req_taken) begin
			// stalled: payload stays as it is
		end else if (gap_left != 0) begin
			req_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (req_backlog.size() == 0) begin
			req_valid <= 1'b0;
		end else if (req_backlog[0].drain) begin
			req_valid <= 1'b0;
			if (rsp_due.size() == 0)
				void'(req_backlog.pop_front());
		end else if (req_backlog.size() >= TAIL_ITEMS &&
				$urandom_range(1, 100) <= gap_pct) begin
			req_valid <= 1'b0;
			gap_left <= $urandom_range(0, 8); // idle burst: this cycle plus gap_left more
		end else begin
			nxt = req_backlog.pop_front();
			req_cur    <= nxt;
			req_valid  <= 1'b1;
			op         <= nxt.code;
			window_id  <= nxt.ev.window;
			event_type <= nxt.ev.etype;
			timestamp  <= nxt.ev.stamp;
			pos_x      <= nxt.ev.pos_x;
			pos_y      <= nxt.ev.pos_y;
			size_w     <= nxt.ev.size_w;
			size_h     <= nxt.ev.size_h;
			key_code   <= nxt.ev.key;
			issued <= issued + 1;
			// change the idle mix now and then, calm stretches included
			if (issued % 64 == 63) begin
				case ($urandom_range(0, 2))
					0: gap_pct <= 0;
					1: gap_pct <= 12;
					default: gap_pct <= 40;
				endcase
			end
		end
	end

	// Result side back-pressure in bursts, each held while hold_left counts down
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (req_backlog.size() >= TAIL_ITEMS &&
				$urandom_range(1, 100) <= gap_pct) begin
			rsp_stall <= 1'b1;
			hold_left <= $urandom_range(0, 8);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: checks each result against the oldest prediction, then
	// predicts for a request accepted at the same edge.
	// ---------------------------------------------------------------
	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t %s: expected %0h, got %0h", $time, what, want, got);
		end
	endfunction

	ring_result_t want;

	always @(posedge clk) begin
		req_taken <= req_valid && !req_stall;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (rsp_due.size() == 0) begin
					mismatches++;
					$display("%0t result with none expected: expected nothing, got fill %0d",
						$time, fill_count);
				end else begin
					want = rsp_due.pop_front();
					check_field("event_valid", 32'(want.ev_valid), 32'(event_valid));
					check_field("dropped_oldest", 32'(want.dropped), 32'(dropped_oldest));
					check_field("fill_count", 32'(want.fill), 32'(fill_count));
					check_field("out_window", 32'(want.ev.window), 32'(out_window));
					check_field("out_type", 32'(want.ev.etype), 32'(out_type));
					check_field("out_time", want.ev.stamp, out_time);
					check_field("out_x", 32'(want.ev.pos_x), 32'(out_x));
					check_field("out_y", 32'(want.ev.pos_y), 32'(out_y));
					check_field("out_w", 32'(want.ev.size_w), 32'(out_w));
					check_field("out_h", 32'(want.ev.size_h), 32'(out_h));
					check_field("out_key", want.ev.key, out_key);
				end
			end
			if (req_valid && !req_stall) begin
				rsp_due.push_back(ring_apply(req_cur));
				accepted_items <= accepted_items + 1;
			end
		end
	end

	// Watchdog: a run with no handshake for too long is a hang
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Sequence: directed corner cases, then random segments with a
	// bias each (fill, drain, mixed, purge-heavy).
	// ---------------------------------------------------------------
	req_item_t it;
	int        mode;
	int        seg_len;
	int        roll;
	logic [1:0] code;

	initial begin
		// empty ring: pop, purge and the unused code
		queue_item(event_item(erdop_pkg::OP_POP, 16'h0000));
		queue_item(event_item(erdop_pkg::OP_PURGE, 16'h0000));
		queue_item(event_item(OP_UNUSED, 16'h0000));
		// payload extremes, all zeros and all ones
		it = '0;
		it.code = erdop_pkg::OP_PUSH;
		queue_item(it);
		it = '1;
		it.drain = 1'b0;
		it.code = erdop_pkg::OP_PUSH;
		queue_item(it);
		queue_item(event_item(erdop_pkg::OP_PUSH, 16'h0001));
		queue_item(event_item(erdop_pkg::OP_PUSH, 16'h0002));
		queue_item(event_item(erdop_pkg::OP_PUSH, 16'h0001));
		// unused code with all fields high on a busy ring
		it = '1;
		it.drain = 1'b0;
		it.code = OP_UNUSED;
		queue_item(it);
		queue_item(event_item(erdop_pkg::OP_PURGE, 16'h0007)); // no match
		queue_item(event_item(erdop_pkg::OP_PURGE, 16'h0001)); // removes both window 1 events
		queue_item(event_item(erdop_pkg::OP_POP, 16'h0000));
		queue_item(event_item(erdop_pkg::OP_POP, 16'h0000));
		queue_item(event_item(erdop_pkg::OP_POP, 16'h0000));
		queue_item(event_item(erdop_pkg::OP_POP, 16'h0000)); // empty again
		queue_item(event_item(erdop_pkg::OP_PUSH, 16'hFFFF));
		queue_item(event_item(erdop_pkg::OP_PUSH, 16'hFFFF));
		queue_item(event_item(erdop_pkg::OP_PURGE, 16'hFFFF)); // removes everything
		queue_item(event_item(erdop_pkg::OP_POP, 16'h0000));
		queue_pause();

		mode = 0; // first segment is push-heavy so the ring fills early
		while (item_total < ITEM_GOAL) begin
			seg_len = $urandom_range(20, 60);
			repeat (seg_len) begin
				roll = $urandom_range(0, 99);
				case (mode)
					0: code = roll < 85 ? erdop_pkg::OP_PUSH :
						roll < 93 ? erdop_pkg::OP_POP :
						roll < 98 ? erdop_pkg::OP_PURGE : OP_UNUSED;
					1: code = roll < 15 ? erdop_pkg::OP_PUSH :
						roll < 90 ? erdop_pkg::OP_POP :
						roll < 97 ? erdop_pkg::OP_PURGE : OP_UNUSED;
					2: code = roll < 45 ? erdop_pkg::OP_PUSH :
						roll < 85 ? erdop_pkg::OP_POP :
						roll < 97 ? erdop_pkg::OP_PURGE : OP_UNUSED;
					default: code = roll < 60 ? erdop_pkg::OP_PUSH :
						roll < 70 ? erdop_pkg::OP_POP :
						roll < 98 ? erdop_pkg::OP_PURGE : OP_UNUSED;
				endcase
				queue_item(event_item(code, pick_window()));
			end
			if ($urandom_range(0, 3) == 0)
				queue_pause();
			mode = $urandom_range(0, 3);
		end

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// wait for every item to be taken and answered
		do
			@(negedge clk);
		while (accepted_items != item_total || rsp_due.size() != 0);
		repeat (SETTLE) @(negedge clk);

		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/erdop_pkg.sv
rtl/erdop_ctrl.sv
rtl/erdop_dpath.sv
rtl/event_ring_drop_oldest_purge.sv
test/tb_top.sv
